// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define TPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset cycles included.
`define TPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/tpd_pkg.sv =====
// Types and constants shared by the threshold period detector modules.
`default_nettype none

package tpd_pkg;

  localparam int INDEX_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int POS_W      = 16;
  localparam int QUIET_W    = 16;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    CFG_NOISE_THRESHOLD = 1'b0,
    CFG_QUIET_RUN       = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                scan_end;
  } tpd_in_t;

  typedef struct packed {
    logic [POS_W-1:0] period_start;
    logic [POS_W-1:0] period_end;
    logic             closed_by_scan_end;
  } tpd_out_t;

endpackage

`default_nettype wire

// ===== src/tpd_in_stage.sv =====
// Input register: holds one sample until the core takes it.
`default_nettype none

module tpd_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire tpd_pkg::tpd_in_t in_data,
  output logic                  in_ready,
  input  wire logic             advance,
  output logic                  item_vld,
  output tpd_pkg::tpd_in_t      item
);

  logic             vld_r;
  logic             vld_nxt;
  tpd_pkg::tpd_in_t data_r;

  // Refill while the held item moves on to the core.
  assign in_ready = !vld_r || advance;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = data_r;

endmodule

`default_nettype wire

// ===== src/tpd_core.sv =====
// Scan state: threshold compare, quiet run count and period close.
`default_nettype none

module tpd_core #(
  parameter int INDEX_BITS  = tpd_pkg::INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = tpd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            advance,
  input  wire tpd_pkg::tpd_in_t                item,
  input  wire logic [tpd_pkg::SAMPLE_W-1:0]    noise_threshold,
  input  wire logic [tpd_pkg::QUIET_W-1:0]     required_quiet_run,
  output logic                                 res_vld,
  output tpd_pkg::tpd_out_t                    res
);

  localparam logic [tpd_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= tpd_pkg::SAMPLE_W) ? {tpd_pkg::SAMPLE_W{1'b1}}
                                       : tpd_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [INDEX_BITS-1:0]       INDEX_MAX = {INDEX_BITS{1'b1}};
  localparam logic [tpd_pkg::QUIET_W-1:0] QUIET_MAX = {tpd_pkg::QUIET_W{1'b1}};

  logic                        in_period_r, in_period_nxt;
  logic [INDEX_BITS-1:0]       start_pos_r, start_pos_nxt;
  logic [INDEX_BITS-1:0]       quiet_start_r, quiet_start_nxt;
  logic [tpd_pkg::QUIET_W-1:0] quiet_run_r, quiet_run_nxt;
  logic [INDEX_BITS-1:0]       sample_pos_r, sample_pos_nxt;

  logic [tpd_pkg::SAMPLE_W-1:0] sample_m;
  logic [tpd_pkg::QUIET_W-1:0]  need;
  logic                         loud;

  assign sample_m = item.sample & SAMPLE_MASK;
  assign loud     = sample_m > noise_threshold;
  // A zero run length closes like a run of one.
  assign need     = (required_quiet_run == '0) ? tpd_pkg::QUIET_W'(1) : required_quiet_run;

  always_comb begin
    in_period_nxt   = in_period_r;
    start_pos_nxt   = start_pos_r;
    quiet_start_nxt = quiet_start_r;
    quiet_run_nxt   = quiet_run_r;
    sample_pos_nxt  = (sample_pos_r == INDEX_MAX) ? sample_pos_r
                                                  : sample_pos_r + INDEX_BITS'(1);
    res_vld                = 1'b0;
    res.period_start       = tpd_pkg::POS_W'(start_pos_r);
    res.period_end         = tpd_pkg::POS_W'(sample_pos_r);
    res.closed_by_scan_end = 1'b0;

    if (item.scan_end) begin
      // Last sample is never tested; flush an open period and clear the scan.
      res_vld                = in_period_r;
      res.closed_by_scan_end = 1'b1;
      in_period_nxt          = 1'b0;
      start_pos_nxt          = '0;
      quiet_start_nxt        = '0;
      quiet_run_nxt          = '0;
      sample_pos_nxt         = '0;
    end else if (!in_period_r) begin
      if (loud) begin
        in_period_nxt = 1'b1;
        start_pos_nxt = sample_pos_r;
      end
    end else begin
      if (!loud) begin
        if (quiet_run_r == '0) begin
          quiet_start_nxt = sample_pos_r;
        end
        if (quiet_run_r != QUIET_MAX) begin
          quiet_run_nxt = quiet_run_r + tpd_pkg::QUIET_W'(1);
        end
      end else begin
        quiet_run_nxt = '0;
      end
      res.period_end = tpd_pkg::POS_W'(quiet_start_nxt);
      if (quiet_run_nxt >= need) begin
        res_vld       = 1'b1;
        in_period_nxt = 1'b0;
        quiet_run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_period_r   <= 1'b0;
      start_pos_r   <= '0;
      quiet_start_r <= '0;
      quiet_run_r   <= '0;
      sample_pos_r  <= '0;
    end else if (advance) begin
      in_period_r   <= in_period_nxt;
      start_pos_r   <= start_pos_nxt;
      quiet_start_r <= quiet_start_nxt;
      quiet_run_r   <= quiet_run_nxt;
      sample_pos_r  <= sample_pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tpd_out_stage.sv =====
// Result register: holds one period until the sink takes it.
`default_nettype none

module tpd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              res_vld,
  input  wire tpd_pkg::tpd_out_t res,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tpd_pkg::tpd_out_t      out_data
);

  logic              vld_r;
  logic              vld_nxt;
  tpd_pkg::tpd_out_t data_r;

  assign out_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = res_vld;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== src/threshold_period_detector_top.sv =====
// A sample is held in the input register, then its period in the result register (out_valid).
// Throughput: one sample per cycle while the result register is free; the input register
// refills while it empties.
// Reset: synchronous active-low rst_n empties both registers, clears the scan
// state and sets noise_threshold to 0 and required_quiet_run to 1.
// Top level of the threshold period detector.
`default_nettype none

module threshold_period_detector_top #(
  parameter int INDEX_BITS  = tpd_pkg::INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = tpd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire tpd_pkg::tpd_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tpd_pkg::tpd_out_t                     out_data,
  input  wire logic                             cfg_we,
  input  wire tpd_pkg::cfg_idx_t                cfg_addr,
  input  wire logic [tpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [tpd_pkg::SAMPLE_W-1:0] noise_threshold_r;
  logic [tpd_pkg::QUIET_W-1:0]  quiet_run_cfg_r;

  logic              item_vld;
  tpd_pkg::tpd_in_t  item;
  logic              advance;
  logic              out_free;
  logic              res_vld;
  tpd_pkg::tpd_out_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_threshold_r <= '0;
      quiet_run_cfg_r   <= tpd_pkg::QUIET_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        tpd_pkg::CFG_NOISE_THRESHOLD: noise_threshold_r <= cfg_wdata[tpd_pkg::SAMPLE_W-1:0];
        tpd_pkg::CFG_QUIET_RUN:       quiet_run_cfg_r   <= cfg_wdata[tpd_pkg::QUIET_W-1:0];
        default: ;
      endcase
    end
  end

  // Move the held sample into the core when the result register can take it.
  assign advance = item_vld && out_free;

  tpd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  tpd_core #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .item               (item),
    .noise_threshold    (noise_threshold_r),
    .required_quiet_run (quiet_run_cfg_r),
    .res_vld            (res_vld),
    .res                (res)
  );

  tpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_vld   (res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/tpd_checker.sv =====
// Port-level checks for the threshold period detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module tpd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire tpd_pkg::tpd_in_t               in_data,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire tpd_pkg::tpd_out_t              out_data,
  input wire logic                           cfg_we,
  input wire tpd_pkg::cfg_idx_t              cfg_addr,
  input wire logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic unused_ok;
  assign unused_ok = ^{in_data, cfg_we, cfg_addr, cfg_wdata};

  // Reset empties the result register.
  `TPD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")

  // A stalled result holds.
  `TPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // With the result register empty the input side never stalls.
  `TPD_ASSERT(a_no_stall_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")

  // A fresh result comes from a sample that went through the input register and then straight into the result register.
  `TPD_ASSERT(a_result_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without matching transfer")

endmodule

bind threshold_period_detector_top tpd_checker u_tpd_checker (.*);

`default_nettype wire
